@@ hdl/iqm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqm_pkg
// Shared widths, constants and stage types for the IQ magnitude pipeline.
// ----------------------------------------------------------------------------
package iqm_pkg;

  localparam int IN_W           = 12;              // signed Q11 sample parts
  localparam int SQR_W          = 2 * IN_W - 1;    // one square, at most 2^22
  localparam int SUM_W          = 2 * IN_W;        // I^2 + Q^2, at most 2^23
  localparam int SQ_FRAC_BITS   = 22;
  localparam int MAG_W          = 16;              // unsigned Q16 magnitude
  localparam int ROOT_SHIFT     = 10;
  localparam int RAD_W          = 2 * MAG_W;       // radicand below 2^32
  localparam int REM_W          = MAG_W + 2;       // remainder <= 2 * root
  localparam int ACC_W          = REM_W + 2;
  localparam int BITS_PER_STAGE = 2;               // root bits per stage
  localparam int SQRT_STAGES    = MAG_W / BITS_PER_STAGE;

  // Squares stage
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [SQR_W-1:0] ii;
    logic [SQR_W-1:0] qq;
  } mul_t;

  // Square-root stages (the sum stage fills the first one)
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             sat;
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] root;
  } root_t;

endpackage

`default_nettype wire

@@ hdl/iqm_sample_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqm_sample_if
// Input channel: one complex sample and its last flag per item.
// ----------------------------------------------------------------------------
interface iqm_sample_if;
  import iqm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] in_phase;
  logic signed [IN_W-1:0] quadrature;
  logic                   last_in;

  modport source (output valid, in_phase, quadrature, last_in, input ready);
  modport sink   (input valid, in_phase, quadrature, last_in, output ready);
endinterface

`default_nettype wire

@@ hdl/iqm_mag_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqm_mag_if
// Output channel: one magnitude and its last flag per item.
// ----------------------------------------------------------------------------
interface iqm_mag_if;
  import iqm_pkg::*;

  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             last_out;

  modport source (output valid, magnitude, last_out, input ready);
  modport sink   (input valid, magnitude, last_out, output ready);
endinterface

`default_nettype wire

@@ hdl/iqm_square.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqm_square
// First stage: registered squares of the in-phase and quadrature parts.
// ----------------------------------------------------------------------------
module iqm_square (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [iqm_pkg::IN_W-1:0] in_phase,
  input  wire logic signed [iqm_pkg::IN_W-1:0] quadrature,
  input  wire logic                           last_in,
  output iqm_pkg::mul_t                       q
);
  import iqm_pkg::*;

  logic signed [2*IN_W-1:0] ii_full;
  logic signed [2*IN_W-1:0] qq_full;
  mul_t                     next;

  // Squares are non-negative and at most 2^22, so the sign bit is dropped
  assign ii_full = in_phase * in_phase;
  assign qq_full = quadrature * quadrature;

  always_comb begin
    next.valid = in_valid;
    next.last  = last_in;
    next.ii    = ii_full[SQR_W-1:0];
    next.qq    = qq_full[SQR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= next;
    end
  end
endmodule

`default_nettype wire

@@ hdl/iqm_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqm_sum
// Second stage: squared magnitude, saturation flag and radicand set-up.
// ----------------------------------------------------------------------------
module iqm_sum (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire iqm_pkg::mul_t d,
  output iqm_pkg::root_t     q
);
  import iqm_pkg::*;

  logic [SUM_W-1:0] sum;
  root_t            next;

  assign sum = SUM_W'(d.ii) + SUM_W'(d.qq);

  // sum >= 2^22 gives a root of 2^16 or more: saturate.  Below that the
  // shifted sum fits 32 bits and its root fits 16.
  always_comb begin
    next.valid = d.valid;
    next.last  = d.last;
    next.sat   = |sum[SUM_W-1:SQ_FRAC_BITS];
    next.rad   = {sum[SQ_FRAC_BITS-1:0], {ROOT_SHIFT{1'b0}}};
    next.rem   = '0;
    next.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= next;
    end
  end
endmodule

`default_nettype wire

@@ hdl/iqm_sqrt_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqm_sqrt_stage
// One stage of the digit-by-digit integer square root: two root bits.
// ----------------------------------------------------------------------------
module iqm_sqrt_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire iqm_pkg::root_t d,
  output iqm_pkg::root_t      q
);
  import iqm_pkg::*;

  root_t            next;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] trial;

  always_comb begin
    next  = d;
    acc   = '0;
    trial = '0;
    for (int j = 0; j < BITS_PER_STAGE; j++) begin
      // Bring down the next two radicand bits, try root*4+1
      acc   = {next.rem, next.rad[RAD_W-1 -: 2]};
      trial = ACC_W'({next.root, 2'b01});
      if (acc >= trial) begin
        next.rem  = REM_W'(acc - trial);
        next.root = {next.root[MAG_W-2:0], 1'b1};
      end else begin
        next.rem  = acc[REM_W-1:0];
        next.root = {next.root[MAG_W-2:0], 1'b0};
      end
      next.rad = {next.rad[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= next;
    end
  end
endmodule

`default_nettype wire

@@ hdl/iq_magnitude_q11_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iq_magnitude_q11_unit
// Magnitude of a complex Q11 sample, floor(sqrt(I^2+Q^2)*32), saturated.
// ----------------------------------------------------------------------------
// Takes one complex sample per item and returns one 16-bit magnitude per
// item, in order, with the last flag copied across. Throughput is one item
// per clock while the output takes results; there are ten register stages:
// one stage of squares, one of summing, and eight square-root stages
// producing two root bits each. The square-root chain sets the depth.
// Each stage moves on when it is empty or the one after it moves, so bubbles
// close up and the input keeps taking items while a result waits at the
// output, until every stage is full. Results are exact (truncated integer
// root); squared magnitudes of 2^22 or more, e.g. both parts at -2048,
// give 65535.
// ----------------------------------------------------------------------------
module iq_magnitude_q11_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  iqm_sample_if.sink samples,
  iqm_mag_if.source  result
);
  import iqm_pkg::*;

  localparam int NSTAGE = SQRT_STAGES + 2;   // squares, sum, root stages

  mul_t              mul_q;
  root_t             stage_q [SQRT_STAGES+1]; // [0] sum stage, then root stages
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // Valid bits, stage 0 nearest the input
  always_comb begin
    vld[0] = mul_q.valid;
    for (int k = 0; k <= SQRT_STAGES; k++) begin
      vld[k+1] = stage_q[k].valid;
    end
  end

  // Stage advance: free slot or the downstream stage advances too
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || result.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign samples.ready = en[0];

  iqm_square u_square (
    .clk        (clk),
    .rst        (rst),
    .en         (en[0]),
    .in_valid   (samples.valid),
    .in_phase   (samples.in_phase),
    .quadrature (samples.quadrature),
    .last_in    (samples.last_in),
    .q          (mul_q)
  );

  iqm_sum u_sum (
    .clk (clk),
    .rst (rst),
    .en  (en[1]),
    .d   (mul_q),
    .q   (stage_q[0])
  );

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_root
    iqm_sqrt_stage u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en[g+2]),
      .d   (stage_q[g]),
      .q   (stage_q[g+1])
    );
  end

  // Output straight from the last root stage register
  assign result.valid     = stage_q[SQRT_STAGES].valid;
  assign result.last_out  = stage_q[SQRT_STAGES].last;
  assign result.magnitude = stage_q[SQRT_STAGES].sat ? {MAG_W{1'b1}}
                                                     : stage_q[SQRT_STAGES].root;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An empty output slot must never hold the input off
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> samples.ready)
    else $error("input stalled with output slot empty");

  // Finished root leaves a remainder no larger than twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (stage_q[SQRT_STAGES].rem <= {1'b0, stage_q[SQRT_STAGES].root, 1'b0}))
    else $error("square-root remainder out of range");

  // Nothing comes out in the cycle after reset
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid straight after reset");

endmodule

`default_nettype wire

@@ test/tb_iq_magnitude_q11_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iq_magnitude_q11_checker
// Watches both channels of the IQ magnitude unit and checks every result.
// Each accepted sample has its magnitude predicted by an exact integer root.
// The prediction is queued and compared, in order, with the result items.
// ----------------------------------------------------------------------------
module tb_iq_magnitude_q11_checker (
  input  logic  clk,
  input  logic  rst,
  iqm_sample_if samples,
  iqm_mag_if    result,
  output int    mismatch_count,
  output int    pending_count
);
  import iqm_pkg::*;

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic             last;
  } mag_item_t;

  mag_item_t expected_mags[$];

  // floor(sqrt((I^2 + Q^2) << 10)), saturated to 16 bits
  function automatic logic [MAG_W-1:0] iq_magnitude(logic signed [IN_W-1:0] ip,
                                                     logic signed [IN_W-1:0] qd);
    longint unsigned sq;
    longint unsigned rad;
    longint unsigned root;
    longint unsigned probe;
    sq    = longint'(ip) * longint'(ip) + longint'(qd) * longint'(qd);
    rad   = sq << ROOT_SHIFT;
    root  = 0;
    probe = 64'd1 << 34;
    while (probe > rad) probe = probe >> 2;
    while (probe != 0) begin
      if (rad >= root + probe) begin
        rad  = rad - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (root > 64'hFFFF) return '1;
    return root[MAG_W-1:0];
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  always @(posedge clk) begin
    mag_item_t want;
    if (!rst) begin
      if (samples.valid && samples.ready) begin
        want.magnitude = iq_magnitude(samples.in_phase, samples.quadrature);
        want.last      = samples.last_in;
        expected_mags.push_back(want);
      end
      if (result.valid && result.ready) begin
        if (expected_mags.size() == 0) begin
          $error("result item with no sample outstanding: magnitude %0d last %0d",
                 result.magnitude, result.last_out);
          mismatch_count++;
        end else begin
          want = expected_mags.pop_front();
          if (result.magnitude !== want.magnitude) begin
            $error("magnitude: expected %0d, got %0d", want.magnitude, result.magnitude);
            mismatch_count++;
          end
          if (result.last_out !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, result.last_out);
            mismatch_count++;
          end
        end
      end
    end
    pending_count = expected_mags.size();
  end

endmodule

@@ test/tb_iq_magnitude_q11_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iq_magnitude_q11_unit
// Stimulus and verdict for the IQ magnitude unit.
// A directed set covers the corners (zero, full scale, the saturation edge),
// then random samples flow with random gaps on both sides, calm stretches
// with no gaps and one long output hold-off that backs up the pipeline.
// Checking is done by the checker instantiated beside the unit.
// ----------------------------------------------------------------------------
module tb_iq_magnitude_q11_unit;
  import iqm_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 150;   // long output hold-off
  localparam int HOLD_AT      = 200;   // ... once this many items are in
  localparam int DRAIN_CYCLES = 20;    // pipeline is ten deep
  localparam int N_DIR        = 20;

  // corners: zero, each axis at both ends, both parts at -2048 (saturates),
  // just below and just above the point where the root leaves 16 bits
  localparam logic [IN_W-1:0] DIR_I [N_DIR] = '{12'sd0, 12'sd2047, -12'sd2048,
                                  12'sd0, 12'sd0,
                                  -12'sd2048, 12'sd2047, -12'sd2048, 12'sd2047,
                                  12'sd1, -12'sd1, 12'sd1448, 12'sd1449,
                                  -12'sd1448, 12'sd1024, 12'sd3, -12'sd2047,
                                  12'sd1, 12'sd2047, -12'sd1};
  localparam logic [IN_W-1:0] DIR_Q [N_DIR] = '{12'sd0, 12'sd0, 12'sd0,
                                  12'sd2047, -12'sd2048,
                                  -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048,
                                  12'sd0, -12'sd1, 12'sd1448, 12'sd1448,
                                  -12'sd1449, -12'sd1024, 12'sd4, 12'sd1,
                                  12'sd1, -12'sd1, 12'sd2047};

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatch_count;
  int   pending_count;
  int   accepted_in = 0;
  bit   calm = 1'b0;                   // no new random idles on either side while set

  iqm_sample_if samples ();
  iqm_mag_if    result ();

  always #1 clk = ~clk;

  iq_magnitude_q11_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .result  (result)
  );

  tb_iq_magnitude_q11_checker mag_check (
    .clk            (clk),
    .rst            (rst),
    .samples        (samples),
    .result         (result),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // Offer one sample and hold it until the unit takes it; returns at the
  // falling edge after acceptance with valid still high
  task automatic send_sample(input logic [IN_W-1:0] ip, input logic [IN_W-1:0] qd,
                             input logic lst);
    samples.valid      <= 1'b1;
    samples.in_phase   <= ip;
    samples.quadrature <= qd;
    samples.last_in    <= lst;
    do @(posedge clk); while (!samples.ready);
    @(negedge clk);
  endtask

  // Unless calm, maybe idle the input a random number of cycles, junk on data lines
  task automatic sender_idle();
    int n;
    if (calm || $urandom_range(0, 99) < 55) return;
    n = idle_len();
    samples.valid      <= 1'b0;
    samples.in_phase   <= IN_W'($urandom_range(0, 4095));
    samples.quadrature <= IN_W'($urandom_range(0, 4095));
    samples.last_in    <= 1'($urandom_range(0, 1));
    repeat (n) @(negedge clk);
  endtask

  // Random part: mostly uniform codes, some near full scale, zero or the saturation edge
  function automatic logic [IN_W-1:0] random_part();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IN_W'($urandom_range(0, 4095));
    if (r < 80) return IN_W'($urandom_range(2040, 2055)); // around +/- full scale
    if (r < 90) return IN_W'($urandom_range(0, 8) - 4);   // around zero
    return IN_W'($urandom_range(1400, 1500));            // around the saturation edge
  endfunction

  always @(posedge clk)
    if (!rst && samples.valid && samples.ready) accepted_in <= accepted_in + 1;

  // Sample side
  initial begin
    samples.valid      <= 1'b0;
    samples.in_phase   <= '0;
    samples.quadrature <= '0;
    samples.last_in    <= 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < N_DIR; k++) begin
      send_sample(DIR_I[k], DIR_Q[k], k[0]);
      sender_idle();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 120) % 4) == 1;
      send_sample(random_part(), random_part(), $urandom_range(0, 7) == 0);
      sender_idle();
    end
    calm = 1'b0;
    samples.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("tb_iq_magnitude_q11_unit: PASS");
    else
      $display("tb_iq_magnitude_q11_unit: FAIL");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off while samples keep coming
  initial begin
    int  hold;
    bit  held_once;
    hold      = 0;
    held_once = 1'b0;
    result.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result.ready <= 1'b0;
        hold--;
      end else if (!held_once && accepted_in >= HOLD_AT) begin
        held_once = 1'b1;
        hold = HOLD_CYCLES - 1;
        result.ready <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        result.ready <= 1'b1;
      end else begin
        hold = idle_len() - 1;
        result.ready <= 1'b0;
      end
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("tb_iq_magnitude_q11_unit: FAIL");
    $finish;
  end

endmodule
